[rtl/ate_pkg.sv]
// adaptive timeout estimator: shared widths, opcodes, register indexes and reset values
// no dependencies; used by adaptive_timeout_estimator_core
package ate_pkg;

	localparam int OP_W      = 2;
	localparam int RTT_W     = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W     = 48;
	localparam int TMO_W     = 32;
	localparam int AVG_W     = 32;

	localparam logic [OP_W-1:0] OP_RESET  = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_RELAX  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_FLOOR   = 2'd1;

	localparam logic [CFG_W-1:0] RST_INITIAL_TIMEOUT = 24'd100000;
	localparam logic [CFG_W-1:0] RST_TIMEOUT_FLOOR   = 24'd50000;

endpackage

[rtl/adaptive_timeout_estimator_core.sv]
// adaptive timeout estimator top level: ewma of round-trip time, peak sample and timeout
// depends on ate_pkg
//
// Takes one word per cycle while in_stall is low and returns one result word per input word, by way
// of the input register and then the result register. The state update (running average,
// peak sample, timeout) is one short combinational add, compare and saturate path,
// so back-to-back words each see the state left by the one before. The input side
// keeps accepting while a result waits, as long as the result register is being drained or
// is empty. Configuration writes are always taken (cfg_ready is held high) and apply to the
// next reset, update or relax word.
module adaptive_timeout_estimator_core #(
	parameter int AVG_SHIFT    = 7,
	parameter int MARGIN_SHIFT = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ate_pkg::OP_W-1:0]           opcode,
	input  logic [ate_pkg::RTT_W-1:0]          rtt_sample_us,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ate_pkg::TMO_W-1:0]          timeout_us,
	output logic [ate_pkg::AVG_W-1:0]          avg_rtt_us,
	output logic [ate_pkg::RTT_W-1:0]          max_rtt_us,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ate_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ate_pkg::CFG_W-1:0]          cfg_data
);

	localparam int ACC_W  = ate_pkg::ACC_W;
	localparam int TMO_W  = ate_pkg::TMO_W;
	localparam int AVG_W  = ate_pkg::AVG_W;
	localparam int RTT_W  = ate_pkg::RTT_W;
	localparam int CFG_W  = ate_pkg::CFG_W;
	localparam int DIFF   = AVG_SHIFT - MARGIN_SHIFT;
	localparam int SH_DN  = (DIFF >= 0) ? DIFF : 0;
	localparam int SH_UP  = (DIFF < 0) ? -DIFF : 0;
	localparam int UP_W   = ACC_W + AVG_SHIFT;
	localparam int DN_W   = ACC_W + MARGIN_SHIFT;
	localparam int SUM_W  = ACC_W + 1;

	localparam logic [63:0] RST_ACC64 =
		(64'(ate_pkg::RST_INITIAL_TIMEOUT) << SH_DN) >> SH_UP;
	localparam logic [ACC_W-1:0] RST_ACC = ACC_W'(RST_ACC64);
	localparam logic [63:0] RST_DN64 = (64'(RST_ACC) >> SH_DN) << SH_UP;
	localparam logic [63:0] RST_FL64 =
		(RST_DN64 < 64'(ate_pkg::RST_TIMEOUT_FLOOR)) ?
		64'(ate_pkg::RST_TIMEOUT_FLOOR) : RST_DN64;
	localparam logic [TMO_W-1:0] RST_CUR =
		(RST_FL64 > 64'({TMO_W{1'b1}})) ? {TMO_W{1'b1}} : TMO_W'(RST_FL64);

	// configuration registers
	logic [CFG_W-1:0] initial_timeout_q;
	logic [CFG_W-1:0] timeout_floor_q;

	// estimator state
	logic [ACC_W-1:0] acc_q;
	logic [RTT_W-1:0] max_q;
	logic [TMO_W-1:0] cur_q;

	// input register
	logic                     valid_s1;
	logic [ate_pkg::OP_W-1:0] opcode_s1;
	logic [RTT_W-1:0]         sample_s1;

	// next-state logic
	logic              out_free;
	logic              advance;
	logic [ACC_W-1:0]  acc_shr;
	logic [SUM_W-1:0]  acc_base;
	logic [SUM_W-1:0]  fold_in;
	logic [SUM_W-1:0]  fold_sum;
	logic [ACC_W-1:0]  fold_sat;
	logic [UP_W-1:0]   init_up;
	logic [ACC_W-1:0]  init_scaled;
	logic [ACC_W-1:0]  acc_n;
	logic [RTT_W-1:0]  max_n;
	logic [TMO_W-1:0]  cur_n;
	logic              recalc;
	logic [DN_W-1:0]   acc_dn;
	logic [DN_W-1:0]   acc_fl;
	logic [ACC_W-1:0]  avg_full;
	logic [AVG_W-1:0]  avg_n;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !out_free;
	assign advance   = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_timeout_q <= ate_pkg::RST_INITIAL_TIMEOUT;
			timeout_floor_q   <= ate_pkg::RST_TIMEOUT_FLOOR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ate_pkg::CFG_INITIAL_TIMEOUT: initial_timeout_q <= cfg_data;
				ate_pkg::CFG_TIMEOUT_FLOOR:   timeout_floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			sample_s1 <= rtt_sample_us;
		end
	end

	always_comb begin
		acc_shr     = acc_q >> AVG_SHIFT;
		acc_base    = {1'b0, acc_q} - {1'b0, acc_shr};
		init_up     = (UP_W'(initial_timeout_q) << SH_DN) >> SH_UP;
		init_scaled = (init_up > UP_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : ACC_W'(init_up);
		fold_in     = SUM_W'(sample_s1);
		acc_n       = acc_q;
		max_n       = max_q;
		recalc      = 1'b0;
		unique case (opcode_s1)
			ate_pkg::OP_RESET: begin
				max_n  = '0;
				recalc = 1'b1;
			end
			ate_pkg::OP_UPDATE: begin
				max_n  = (sample_s1 > max_q) ? sample_s1 : max_q;
				recalc = 1'b1;
			end
			ate_pkg::OP_RELAX: begin
				fold_in = SUM_W'({cur_q, 1'b0});
				recalc  = 1'b1;
			end
			default: ;
		endcase
		fold_sum = acc_base + fold_in;
		fold_sat = fold_sum[SUM_W-1] ? {ACC_W{1'b1}} : fold_sum[ACC_W-1:0];
		if (opcode_s1 == ate_pkg::OP_RESET) begin
			acc_n = init_scaled;
		end else if (recalc) begin
			acc_n = fold_sat;
		end
		acc_dn = (DN_W'(acc_n) >> SH_DN) << SH_UP;
		acc_fl = (acc_dn < DN_W'(timeout_floor_q)) ? DN_W'(timeout_floor_q) : acc_dn;
		if (!recalc) begin
			cur_n = cur_q;
		end else if (acc_fl > DN_W'({TMO_W{1'b1}})) begin
			cur_n = {TMO_W{1'b1}};
		end else begin
			cur_n = acc_fl[TMO_W-1:0];
		end
		avg_full = acc_n >> AVG_SHIFT;
		avg_n    = (avg_full > ACC_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}} : avg_full[AVG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= RST_ACC;
			max_q <= '0;
			cur_q <= RST_CUR;
		end else if (advance) begin
			acc_q <= acc_n;
			max_q <= max_n;
			cur_q <= cur_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			timeout_us <= cur_n;
			avg_rtt_us <= avg_n;
			max_rtt_us <= max_n;
		end
	end

endmodule

[test/adaptive_timeout_estimator_core_tb.sv]
// testbench for adaptive_timeout_estimator_core: queued words, random idling and back-pressure,
// every result checked against an in-bench estimator model with its own registers
// depends on ate_pkg and the core only
`timescale 1ns / 1ps

module adaptive_timeout_estimator_core_tb;

	localparam int OP_W      = ate_pkg::OP_W;
	localparam int RTT_W     = ate_pkg::RTT_W;
	localparam int CFG_IDX_W = ate_pkg::CFG_IDX_W;
	localparam int CFG_W     = ate_pkg::CFG_W;
	localparam int TMO_W     = ate_pkg::TMO_W;
	localparam int AVG_W     = ate_pkg::AVG_W;

	localparam int AVG_SHIFT    = 7;
	localparam int MARGIN_SHIFT = 2;
	localparam int SCALE_GAP    = AVG_SHIFT - MARGIN_SHIFT;
	localparam int WORD_TARGET  = 1550;
	localparam int QUIET_LIMIT  = 3000;

	localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic [63:0] ACC_CEIL = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] U32_CEIL = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [RTT_W-1:0] rtt;
	} est_word_t;

	typedef struct packed {
		logic [TMO_W-1:0] timeout;
		logic [AVG_W-1:0] average;
		logic [RTT_W-1:0] peak;
	} est_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode = '0;
	logic [RTT_W-1:0]     rtt_sample_us = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [TMO_W-1:0]     timeout_us;
	logic [AVG_W-1:0]     avg_rtt_us;
	logic [RTT_W-1:0]     max_rtt_us;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	adaptive_timeout_estimator_core #(
		.AVG_SHIFT    (AVG_SHIFT),
		.MARGIN_SHIFT (MARGIN_SHIFT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.rtt_sample_us (rtt_sample_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.timeout_us    (timeout_us),
		.avg_rtt_us    (avg_rtt_us),
		.max_rtt_us    (max_rtt_us),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	est_word_t   words_to_send[$];
	est_result_t pending_results[$];
	int          words_queued = 0;
	int          errors = 0;
	int          quiet_cycles = 0;
	int          src_idle_pct = 18;
	int          sink_idle_pct = 18;
	int          sink_hold = 0;
	bit          sink_hold_req = 1'b0;
	bit          src_pause = 1'b0;
	bit          in_taken = 1'b0;

	// estimator model state and its own copy of the registers
	logic [63:0]      est_acc;
	logic [RTT_W-1:0] est_peak;
	logic [TMO_W-1:0] est_timeout;
	logic [CFG_W-1:0] cfg_initial;
	logic [CFG_W-1:0] cfg_floor;

	function automatic logic [63:0] acc_from_timeout(logic [63:0] v);
		logic [63:0] r;
		r = (SCALE_GAP >= 0) ? (v << SCALE_GAP) : (v >> (-SCALE_GAP));
		return (r > ACC_CEIL) ? ACC_CEIL : r;
	endfunction

	task automatic refresh_timeout();
		logic [63:0] t;
		t = (SCALE_GAP >= 0) ? (est_acc >> SCALE_GAP) : (est_acc << (-SCALE_GAP));
		if (t < 64'(cfg_floor))
			t = 64'(cfg_floor);
		est_timeout = (t > U32_CEIL) ? '1 : t[TMO_W-1:0];
	endtask

	task automatic blend_into_average(logic [63:0] x);
		logic [63:0] n;
		n = est_acc - (est_acc >> AVG_SHIFT) + x;
		est_acc = (n > ACC_CEIL) ? ACC_CEIL : n;
	endtask

	task automatic restart_estimator();
		est_peak = '0;
		est_acc = acc_from_timeout(64'(cfg_initial));
		refresh_timeout();
	endtask

	task automatic advance_estimator(logic [OP_W-1:0] op, logic [RTT_W-1:0] rtt);
		logic [63:0] avg;
		est_result_t r;
		case (op)
			ate_pkg::OP_RESET: restart_estimator();
			ate_pkg::OP_UPDATE: begin
				if (rtt > est_peak)
					est_peak = rtt;
				blend_into_average(64'(rtt));
				refresh_timeout();
			end
			ate_pkg::OP_RELAX: begin
				blend_into_average(64'(est_timeout) << 1);
				refresh_timeout();
			end
			default: ;
		endcase
		avg = est_acc >> AVG_SHIFT;
		r.timeout = est_timeout;
		r.average = (avg > U32_CEIL) ? '1 : avg[AVG_W-1:0];
		r.peak = est_peak;
		pending_results.push_back(r);
	endtask

	task automatic note_failure(string what);
		errors++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic push_word(logic [OP_W-1:0] op, logic [RTT_W-1:0] rtt);
		est_word_t w;
		w.op = op;
		w.rtt = rtt;
		words_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (words_to_send.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_setting();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(200000, 1000));
			3: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(4000));
		endcase
	endfunction

	// monitor: register writes, accepted words, results, quiet-cycle count
	always @(posedge clk) begin
		est_result_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					ate_pkg::CFG_INITIAL_TIMEOUT: cfg_initial = cfg_data;
					ate_pkg::CFG_TIMEOUT_FLOOR:   cfg_floor = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				advance_estimator(opcode, rtt_sample_us);
				in_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("unexpected result timeout %0d avg %0d max %0d",
						timeout_us, avg_rtt_us, max_rtt_us));
				end else begin
					want = pending_results.pop_front();
					if (timeout_us !== want.timeout)
						note_failure($sformatf("timeout_us expected %0d got %0d",
							want.timeout, timeout_us));
					if (avg_rtt_us !== want.average)
						note_failure($sformatf("avg_rtt_us expected %0d got %0d",
							want.average, avg_rtt_us));
					if (max_rtt_us !== want.peak)
						note_failure($sformatf("max_rtt_us expected %0d got %0d",
							want.peak, max_rtt_us));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	// driver: next word goes out once the current one has been taken
	always @(negedge clk) begin
		est_word_t w;
		if (arst_n && (in_taken || !in_valid)) begin
			in_taken = 1'b0;
			if (src_pause || words_to_send.size() == 0 || $urandom_range(99) < src_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				w = words_to_send.pop_front();
				opcode <= w.op;
				rtt_sample_us <= w.rtt;
				in_valid <= 1'b1;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (sink_hold_req) begin
			sink_hold = 300;
			sink_hold_req = 1'b0;
		end
		if (sink_hold > 0) begin
			sink_hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		int phase;
		int seg;
		int target;
		int centre;
		int jittered;
		cfg_initial = ate_pkg::RST_INITIAL_TIMEOUT;
		cfg_floor = ate_pkg::RST_TIMEOUT_FLOOR;
		restart_estimator();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words on the reset-time registers
		push_word(ate_pkg::OP_UPDATE, '0);
		push_word(ate_pkg::OP_UPDATE, '1);
		push_word(ate_pkg::OP_UPDATE, 24'd1);
		push_word(ate_pkg::OP_UPDATE, 24'h800000);
		push_word(ate_pkg::OP_RELAX, '0);
		push_word(ate_pkg::OP_RELAX, '1);
		push_word(OP_SPARE, '1);
		push_word(OP_SPARE, '0);
		push_word(ate_pkg::OP_RESET, '1);
		push_word(ate_pkg::OP_UPDATE, 24'h555555);
		wait_idle();
		write_reg(ate_pkg::CFG_INITIAL_TIMEOUT, '0);
		write_reg(ate_pkg::CFG_TIMEOUT_FLOOR, '0);
		write_reg(CFG_SPARE_2, '1);
		write_reg(CFG_SPARE_3, 24'h5A5A5A);
		// new registers only show once something recomputes
		push_word(OP_SPARE, 24'h2AAAAA);
		push_word(ate_pkg::OP_RELAX, '0);
		push_word(ate_pkg::OP_RESET, '0);
		push_word(ate_pkg::OP_UPDATE, '0);
		push_word(ate_pkg::OP_RELAX, '0);
		push_word(ate_pkg::OP_UPDATE, '1);
		push_word(ate_pkg::OP_RELAX, '1);
		wait_idle();
		write_reg(ate_pkg::CFG_INITIAL_TIMEOUT, '1);
		write_reg(ate_pkg::CFG_TIMEOUT_FLOOR, '1);
		push_word(ate_pkg::OP_UPDATE, '0);
		push_word(ate_pkg::OP_RESET, 24'h123456);
		push_word(ate_pkg::OP_RELAX, '0);
		push_word(ate_pkg::OP_UPDATE, 24'hAAAAAA);

		for (phase = 0; words_queued < WORD_TARGET; phase++) begin
			wait_idle();
			if (phase == 0) begin
				write_reg(ate_pkg::CFG_INITIAL_TIMEOUT, '1);
				write_reg(ate_pkg::CFG_TIMEOUT_FLOOR, '1);
			end else if (phase == 1) begin
				write_reg(ate_pkg::CFG_INITIAL_TIMEOUT, '0);
				write_reg(ate_pkg::CFG_TIMEOUT_FLOOR, '0);
			end else begin
				write_reg(ate_pkg::CFG_INITIAL_TIMEOUT, pick_setting());
				write_reg(ate_pkg::CFG_TIMEOUT_FLOOR, pick_setting());
			end
			if ($urandom_range(2) == 0)
				write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_W'($urandom));
			src_idle_pct = (phase == 2) ? 0 : 18;
			sink_idle_pct = src_idle_pct;
			push_word(ate_pkg::OP_RESET, RTT_W'($urandom));
			// long relax run drives timeout and average into saturation
			if (phase == 0)
				repeat (320) push_word(ate_pkg::OP_RELAX, RTT_W'($urandom));
			target = words_queued + 150;
			while (words_queued < target) begin
				seg = $urandom_range(99);
				if (seg < 55) begin
					centre = ($urandom_range(3) == 0) ? $urandom_range(2000)
						: $urandom_range(24'hFFFFFF);
					repeat ($urandom_range(30, 4)) begin
						jittered = centre + $urandom_range(centre / 8);
						if (jittered > 24'hFFFFFF)
							jittered = 24'hFFFFFF;
						if ($urandom_range(4) == 0)
							push_word(ate_pkg::OP_UPDATE, RTT_W'($urandom));
						else
							push_word(ate_pkg::OP_UPDATE, RTT_W'(jittered));
					end
				end else if (seg < 78) begin
					repeat ($urandom_range(8, 1))
						push_word(ate_pkg::OP_RELAX, RTT_W'($urandom));
				end else if (seg < 86) begin
					push_word(ate_pkg::OP_RESET, RTT_W'($urandom));
				end else if (seg < 92) begin
					push_word(OP_SPARE, RTT_W'($urandom));
				end else begin
					push_word(OP_W'($urandom), RTT_W'($urandom));
				end
			end
			if (phase == 3)
				sink_hold_req = 1'b1;
			if (phase == 4) begin
				while (words_to_send.size() > 75)
					@(posedge clk);
				src_pause = 1'b1;
				while (in_valid || pending_results.size() != 0)
					@(posedge clk);
				src_pause = 1'b0;
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/ate_pkg.sv
rtl/adaptive_timeout_estimator_core.sv
test/adaptive_timeout_estimator_core_tb.sv
